FILE: src/lfs_pkg.sv
// lfs_pkg: shared types, constants and the microcode program of the line follower.
// Used by lfs_seq, lfs_dp and line_follow_steering; depends on nothing else.
package lfs_pkg;

	localparam int NUM_SENSORS = 10;
	localparam int ERR_W       = 5;
	localparam int SPEED_W     = 14;
	localparam int STEER_W     = 15;
	localparam int GAIN_W      = 16;
	localparam int INTEG_W     = 8;
	localparam int MULB_W      = 9;
	localparam int PROD_W      = GAIN_W + MULB_W;
	localparam int ACC_W       = 27;
	localparam int DIV_STEPS   = 6;
	localparam int IN_W        = 16;
	localparam int OUT_W       = 48;

	// sensor weight by input bit, bit 9 is the leftmost sensor
	localparam logic signed [ERR_W-1:0] WEIGHT [NUM_SENSORS] = '{
		5'sd11, 5'sd9, 5'sd7, 5'sd5, 5'sd1, -5'sd2, -5'sd7, -5'sd9, -5'sd11, -5'sd13
	};

	localparam logic signed [ERR_W-1:0]   LOST_ERR    = 5'sd13;
	localparam logic signed [ERR_W-1:0]   SHARP_ERR   = -5'sd8;
	localparam logic signed [INTEG_W:0]   INTEG_MAX   = 9'sd100;
	localparam logic [SPEED_W-1:0]        SHARP_LEFT  = 14'd1700;
	localparam logic [SPEED_W-1:0]        SHARP_RIGHT = 14'd500;

	// configuration register indexes
	localparam logic [2:0] REG_GAIN_P      = 3'd0;
	localparam logic [2:0] REG_GAIN_I      = 3'd1;
	localparam logic [2:0] REG_GAIN_D      = 3'd2;
	localparam logic [2:0] REG_PID_LIMIT   = 3'd3;
	localparam logic [2:0] REG_LEFT_BASE   = 3'd4;
	localparam logic [2:0] REG_RIGHT_BASE  = 3'd5;
	localparam logic [2:0] REG_SPEED_FLOOR = 3'd6;
	localparam logic [2:0] REG_SPEED_CEIL  = 3'd7;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_PREP,
		OP_DIV,
		OP_DIVFIN,
		OP_LOST,
		OP_MUL_P,
		OP_INTEG,
		OP_MUL_I,
		OP_MUL_D,
		OP_ACCD,
		OP_LIMIT,
		OP_MIX,
		OP_SHARP,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_ALL_ACTIVE,
		COND_DIV_MORE,
		COND_SHARP
	} cond_t;

	typedef logic [3:0] pc_t;

	localparam pc_t STEP_PREP   = 4'd0;
	localparam pc_t STEP_DIV    = 4'd1;
	localparam pc_t STEP_DIVFIN = 4'd2;
	localparam pc_t STEP_LOST   = 4'd3;
	localparam pc_t STEP_MUL_P  = 4'd4;
	localparam pc_t STEP_INTEG  = 4'd5;
	localparam pc_t STEP_MUL_I  = 4'd6;
	localparam pc_t STEP_MUL_D  = 4'd7;
	localparam pc_t STEP_ACCD   = 4'd8;
	localparam pc_t STEP_LIMIT  = 4'd9;
	localparam pc_t STEP_MIX    = 4'd10;
	localparam pc_t STEP_SHARP  = 4'd11;
	localparam pc_t STEP_DONE   = 4'd12;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		logic  last;
	} ucode_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} ctrl_t;

	typedef struct packed {
		logic all_active;
		logic div_more;
		logic sharp;
		logic out_hold;
	} flags_t;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		case (pc)
			STEP_PREP:   w = '{OP_PREP,   COND_ALL_ACTIVE, STEP_LOST,  1'b0};
			STEP_DIV:    w = '{OP_DIV,    COND_DIV_MORE,   STEP_DIV,   1'b0};
			STEP_DIVFIN: w = '{OP_DIVFIN, COND_ALWAYS,     STEP_MUL_P, 1'b0};
			STEP_LOST:   w = '{OP_LOST,   COND_NEXT,       STEP_PREP,  1'b0};
			STEP_MUL_P:  w = '{OP_MUL_P,  COND_SHARP,      STEP_SHARP, 1'b0};
			STEP_INTEG:  w = '{OP_INTEG,  COND_NEXT,       STEP_PREP,  1'b0};
			STEP_MUL_I:  w = '{OP_MUL_I,  COND_NEXT,       STEP_PREP,  1'b0};
			STEP_MUL_D:  w = '{OP_MUL_D,  COND_NEXT,       STEP_PREP,  1'b0};
			STEP_ACCD:   w = '{OP_ACCD,   COND_NEXT,       STEP_PREP,  1'b0};
			STEP_LIMIT:  w = '{OP_LIMIT,  COND_NEXT,       STEP_PREP,  1'b0};
			STEP_MIX:    w = '{OP_MIX,    COND_ALWAYS,     STEP_DONE,  1'b0};
			STEP_SHARP:  w = '{OP_SHARP,  COND_NEXT,       STEP_PREP,  1'b0};
			STEP_DONE:   w = '{OP_DONE,   COND_NEXT,       STEP_PREP,  1'b1};
			default:     w = '{OP_NOP,    COND_ALWAYS,     STEP_DONE,  1'b0};
		endcase
		return w;
	endfunction

endpackage

FILE: src/lfs_seq.sv
// lfs_seq: step counter and microcode fetch for the line follower.
// Depends on lfs_pkg; drives the datapath lfs_dp through ctrl_t.
module lfs_seq
	import lfs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	logic   busy_q;
	pc_t    pc_q;
	ucode_t word;
	logic   take;

	assign word     = ucode_rom(pc_q);
	assign in_ready = !busy_q;
	assign ctrl.load = in_valid && !busy_q;
	assign ctrl.op   = busy_q ? word.op : OP_NOP;

	always_comb begin
		case (word.cond)
			COND_ALWAYS:     take = 1'b1;
			COND_ALL_ACTIVE: take = flags.all_active;
			COND_DIV_MORE:   take = flags.div_more;
			COND_SHARP:      take = flags.sharp;
			default:         take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_PREP;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			pc_q   <= STEP_PREP;
		end else if (busy_q) begin
			if (word.last) begin
				if (!flags.out_hold)
					busy_q <= 1'b0;
			end else if (take) begin
				pc_q <= word.target;
			end else begin
				pc_q <= pc_q + 4'd1;
			end
		end
	end

`ifndef SYNTH
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> busy_q && pc_q == STEP_PREP)
		else $error("request did not start program");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= STEP_DONE)
		else $error("step counter out of program");
	a_done_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && word.last && flags.out_hold |=> busy_q && $stable(pc_q))
		else $error("finished without free output slot");
`endif

endmodule

FILE: src/lfs_dp.sv
// lfs_dp: datapath of the line follower: config registers, centroid divider,
// shared multiplier, PID state, speed mixing and the output register. Uses lfs_pkg.
module lfs_dp
	import lfs_pkg::*;
#(
	parameter bit SENSOR_ACTIVE_HIGH = 1'b1,
	parameter bit LOST_FOLLOW_LAST   = 1'b1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	output flags_t              flags,
	input  logic [NUM_SENSORS-1:0] sensor_levels,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [GAIN_W-1:0]   cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_W-1:0]    out_data,
	output logic                out_sharp
);

	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [SPEED_W-1:0]        pid_limit_q, left_base_q, right_base_q, floor_q, ceil_q;

	logic [NUM_SENSORS-1:0]    sample_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_q, err_q;
	logic [5:0]                quo_q;
	logic [3:0]                rem_q, div_q;
	logic [2:0]                div_cnt_q;
	logic                      neg_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [STEER_W-1:0] steer_q;
	logic [SPEED_W-1:0]        left_q, right_q;
	logic                      sharp_q;
	logic                      out_valid_q;
	logic                      out_sharp_q;
	logic [OUT_W-1:0]          out_data_q;

	logic [NUM_SENSORS-1:0]    active;
	logic signed [6:0]         wsum;
	logic [3:0]                count;
	logic [6:0]                wmag;
	logic [4:0]                dshift;
	logic                      dge;
	logic signed [GAIN_W-1:0]  mul_a;
	logic signed [MULB_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [5:0]         err_diff;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [ACC_W-1:0]   lim_pos, lim_neg, acc_adj, acc_shr;
	logic signed [16:0]        mix_l, mix_r;
	logic signed [16:0]        floor_s, ceil_s;
	logic [SPEED_W-1:0]        left_d, right_d;
	logic                      fire;

	function automatic logic [NUM_SENSORS-1:0] sensor_levels_sel(
		input logic [NUM_SENSORS-1:0] s);
		return SENSOR_ACTIVE_HIGH ? s : ~s;
	endfunction

	assign active = sensor_levels_sel(sample_q);

	always_comb begin
		wsum  = '0;
		count = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (active[i]) begin
				wsum  = wsum + 7'(WEIGHT[i]);
				count = count + 4'd1;
			end
		end
	end

	assign wmag   = wsum[6] ? 7'(-wsum) : 7'(wsum);
	assign dshift = {rem_q, quo_q[5]};
	assign dge    = dshift >= {1'b0, div_q};

	assign err_diff = 6'(err_q) - 6'(prev_q);

	always_comb begin
		case (ctrl.op)
			OP_MUL_I: begin
				mul_a = gain_i_q;
				mul_b = MULB_W'(integ_q);
			end
			OP_MUL_D: begin
				mul_a = gain_d_q;
				mul_b = MULB_W'(err_diff);
			end
			default: begin
				mul_a = gain_p_q;
				mul_b = MULB_W'(err_q);
			end
		endcase
	end

	assign prod_d    = mul_a * mul_b;
	assign integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err_q);

	assign lim_pos = $signed({5'd0, pid_limit_q, 8'd0});
	assign lim_neg = -lim_pos;
	assign acc_adj = acc_q + (acc_q[ACC_W-1] ? 27'sd255 : 27'sd0);
	assign acc_shr = acc_adj >>> 8;

	assign floor_s = $signed({3'd0, floor_q});
	assign ceil_s  = $signed({3'd0, ceil_q});
	assign mix_l   = $signed({3'd0, left_base_q}) - 17'(steer_q);
	assign mix_r   = $signed({3'd0, right_base_q}) + 17'(steer_q);

	always_comb begin
		if (mix_l > ceil_s)
			left_d = ceil_q;
		else if (mix_l < floor_s)
			left_d = floor_q;
		else
			left_d = mix_l[SPEED_W-1:0];
		if (mix_r > ceil_s)
			right_d = ceil_q;
		else if (mix_r < floor_s)
			right_d = floor_q;
		else
			right_d = mix_r[SPEED_W-1:0];
	end

	assign fire = (ctrl.op == OP_DONE) && !flags.out_hold;

	assign flags.all_active = count == 4'(NUM_SENSORS);
	assign flags.div_more   = div_cnt_q != 3'(DIV_STEPS - 1);
	assign flags.sharp      = err_q <= SHARP_ERR;
	assign flags.out_hold   = out_valid_q && !out_ready;

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.load)
			sample_q <= sensor_levels;
		case (ctrl.op)
			OP_PREP: begin
				quo_q     <= wmag[5:0];
				neg_q     <= wsum[6];
				div_q     <= (count == 4'd0) ? 4'd1 : count;
				rem_q     <= '0;
				div_cnt_q <= '0;
				sharp_q   <= 1'b0;
			end
			OP_DIV: begin
				rem_q     <= dge ? 4'(dshift - {1'b0, div_q}) : dshift[3:0];
				quo_q     <= {quo_q[4:0], dge};
				div_cnt_q <= div_cnt_q + 3'd1;
			end
			OP_DIVFIN: err_q <= neg_q ? -$signed(quo_q[4:0]) : $signed(quo_q[4:0]);
			OP_LOST: begin
				if (!LOST_FOLLOW_LAST || prev_q == '0)
					err_q <= '0;
				else if (prev_q > 0)
					err_q <= -LOST_ERR;
				else
					err_q <= LOST_ERR;
			end
			OP_MUL_P: begin
				prod_q <= prod_d;
				acc_q  <= '0;
			end
			OP_MUL_I, OP_MUL_D: begin
				prod_q <= prod_d;
				acc_q  <= acc_q + ACC_W'(prod_q);
			end
			OP_ACCD: acc_q <= acc_q + ACC_W'(prod_q);
			OP_LIMIT: begin
				if (acc_q > lim_pos)
					steer_q <= $signed({1'b0, pid_limit_q});
				else if (acc_q < lim_neg)
					steer_q <= -$signed({1'b0, pid_limit_q});
				else
					steer_q <= acc_shr[STEER_W-1:0];
			end
			OP_MIX: begin
				left_q  <= left_d;
				right_q <= right_d;
			end
			OP_SHARP: begin
				steer_q <= '0;
				left_q  <= SHARP_LEFT;
				right_q <= SHARP_RIGHT;
				sharp_q <= 1'b1;
			end
			default: ;
		endcase
		if (fire) begin
			out_data_q  <= {right_q, left_q, steer_q, err_q};
			out_sharp_q <= sharp_q;
		end
	end

	// config, PID state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			pid_limit_q  <= 14'd1000;
			left_base_q  <= 14'd3000;
			right_base_q <= 14'd3000;
			floor_q      <= 14'd0;
			ceil_q       <= 14'd10000;
			integ_q      <= '0;
			prev_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_P:      gain_p_q     <= cfg_data;
					REG_GAIN_I:      gain_i_q     <= cfg_data;
					REG_GAIN_D:      gain_d_q     <= cfg_data;
					REG_PID_LIMIT:   pid_limit_q  <= cfg_data[SPEED_W-1:0];
					REG_LEFT_BASE:   left_base_q  <= cfg_data[SPEED_W-1:0];
					REG_RIGHT_BASE:  right_base_q <= cfg_data[SPEED_W-1:0];
					REG_SPEED_FLOOR: floor_q      <= cfg_data[SPEED_W-1:0];
					default:         ceil_q       <= cfg_data[SPEED_W-1:0];
				endcase
			end
			if (ctrl.op == OP_INTEG) begin
				if (integ_sum > INTEG_MAX)
					integ_q <= INTEG_MAX[INTEG_W-1:0];
				else if (integ_sum < -INTEG_MAX)
					integ_q <= 8'(-INTEG_MAX);
				else
					integ_q <= integ_sum[INTEG_W-1:0];
			end
			if (ctrl.op == OP_MUL_D)
				prev_q <= err_q;
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_sharp = out_sharp_q;

`ifndef SYNTH
	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q <= 8'sd100 && integ_q >= -8'sd100)
		else $error("integral out of bound");
	a_prev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prev_q <= LOST_ERR && prev_q >= -LOST_ERR)
		else $error("previous error out of range");
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("result dropped before taken");
`endif

endmodule

FILE: src/line_follow_steering.sv
// line_follow_steering: top level of the line follower with PID steering.
// Instantiates lfs_seq (microcode sequencer) and lfs_dp (datapath); uses lfs_pkg.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[9:0] sensor_levels
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata error/steer/left/right, tuser sharp
// cfg       in   cfg_we                       cfg_index, cfg_data
//
// One request keeps the program busy through the centroid divider loop and the PID steps
// on the PID path, or through the divider and the sharp-turn step on the sharp-turn path;
// a lost line skips the divider. Both paths are set by the microcode program.
// The next request is taken the cycle after the last step; the result register may
// still be waiting. The final step stalls while the result register is held.
// Reset is asynchronous; no clearing pass is needed.
module line_follow_steering
	import lfs_pkg::*;
#(
	parameter bit SENSOR_ACTIVE_HIGH = 1'b1,
	parameter bit LOST_FOLLOW_LAST   = 1'b1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // [9:0] sensor_levels, rest zero
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // [4:0] line_error, [19:5] steer_value,
	                                        // [33:20] left_wheel, [47:34] right_wheel
	output logic             m_axis_tuser,  // [0] sharp_turn
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [GAIN_W-1:0] cfg_data
);

	ctrl_t  ctrl;
	flags_t flags;

	lfs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.flags    (flags),
		.ctrl     (ctrl)
	);

	lfs_dp #(
		.SENSOR_ACTIVE_HIGH (SENSOR_ACTIVE_HIGH),
		.LOST_FOLLOW_LAST   (LOST_FOLLOW_LAST)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.flags         (flags),
		.sensor_levels (s_axis_tdata[NUM_SENSORS-1:0]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata),
		.out_sharp     (m_axis_tuser)
	);

endmodule
